### sv/psa_pkg.sv
// ============================================================================
// psa_pkg: shared types, constants and address helpers
// Event codes, timing constants and the coarse/fine scroll increment functions
// used by the scroll and address unit.
// ============================================================================
package psa_pkg;

  localparam int unsigned ADDR_W = 15;
  localparam int unsigned CNT_W  = 9;

  // Event codes carried on the mode field. Code 7 has no meaning.
  typedef enum logic [2:0] {
    MODE_CTRL   = 3'd0,
    MODE_MASK   = 3'd1,
    MODE_SCROLL = 3'd2,
    MODE_ADDR   = 3'd3,
    MODE_DATA   = 3'd4,
    MODE_STATUS = 3'd5,
    MODE_TICK   = 3'd6
  } mode_t;

  localparam logic [CNT_W-1:0] DOT_LAST      = 9'd340;
  localparam logic [CNT_W-1:0] LINE_PRE      = 9'd261;
  localparam logic [CNT_W-1:0] LINE_VIS_LAST = 9'd239;
  localparam logic [CNT_W-1:0] LINE_RESET    = 9'd240;
  localparam logic [CNT_W-1:0] DOT_XY        = 9'd256;
  localparam logic [CNT_W-1:0] DOT_HCOPY     = 9'd257;
  localparam logic [CNT_W-1:0] DOT_VCOPY_LO  = 9'd280;
  localparam logic [CNT_W-1:0] DOT_VCOPY_HI  = 9'd304;
  localparam logic [CNT_W-1:0] DOT_PREFETCH  = 9'd328;

  localparam logic [4:0]        CY_LAST_ROW = 5'd29;
  localparam logic [ADDR_W-1:0] ROW_STEP    = 15'd32;
  localparam logic [ADDR_W-1:0] COL_STEP    = 15'd1;
  localparam logic [ADDR_W-1:0] MASK_H      = 15'h041f;
  localparam logic [ADDR_W-1:0] MASK_V      = 15'h7be0;

  // Address-side state, kept together since it moves as one group.
  typedef struct packed {
    logic [ADDR_W-1:0] cur;
    logic [ADDR_W-1:0] lat;
    logic [2:0]        fine;
    logic              toggle;
    logic              step_row;
    logic              render;
  } scroll_state_t;

  // Dot-timed address actions for the dot a tick moves to.
  typedef struct packed {
    logic inc_xy;
    logic copy_h;
    logic copy_v;
    logic inc_x;
  } dot_act_t;

  // Coarse X increment; wrapping past column 31 switches horizontal nametable.
  function automatic logic [ADDR_W-1:0] bump_x(input logic [ADDR_W-1:0] v);
    logic [ADDR_W-1:0] r;
    if (v[4:0] == 5'h1f) begin
      r = {v[14:11], ~v[10], v[9:5], 5'd0};
    end else begin
      r = {v[14:5], v[4:0] + 5'd1};
    end
    return r;
  endfunction

  // Fine Y increment with carry into coarse Y. Row 29 wraps and switches the
  // vertical nametable; row 31 wraps without switching.
  function automatic logic [ADDR_W-1:0] bump_y(input logic [ADDR_W-1:0] v);
    logic [ADDR_W-1:0] r;
    logic [4:0]        cy;
    logic              nty;
    cy  = v[9:5];
    nty = v[11];
    if (v[14:12] != 3'd7) begin
      r = {v[14:12] + 3'd1, v[11:0]};
    end else begin
      if (cy == CY_LAST_ROW) begin
        cy  = 5'd0;
        nty = ~nty;
      end else if (cy == 5'h1f) begin
        cy = 5'd0;
      end else begin
        cy = cy + 5'd1;
      end
      r = {3'd0, nty, v[10], cy, v[4:0]};
    end
    return r;
  endfunction

endpackage

### sv/ppu_scroll_address_unit.sv
// ============================================================================
// ppu_scroll_address_unit: scroll and address unit of a tile video processor
// Tracks the current and temporary VRAM addresses, fine X, the write toggle
// and dot/scanline timing, and reports the full state after every event.
// ============================================================================
//
// Usage:
//   The input channel (in_valid, in_ready, mode, data_byte) carries one item
//   per CPU register event or per one-dot tick. The output channel
//   (out_valid, out_ready and the seven state fields) returns exactly one
//   item per input item, in order, showing the state after that event.
//   An accepted item is held in the input register, moves into the state
//   registers at the next edge when the output slot is free, and is offered
//   on the output from then on.
//   Throughput is one item per cycle while out_ready stays high: the input
//   register is freed in the same cycle its item moves into the state/result
//   register, and in_ready follows out_ready through both registers.
//   The state registers double as the result register. They change only when
//   an item moves in, so a stalled result holds steady while the next item
//   waits in the input register; with both full and out_ready low, in_ready drops.
//   Synchronous reset empties both stages and sets the state to its power-up
//   values: addresses, fine X, toggle, step and rendering enable zero, dot
//   340, scanline 240, even frame.
//
// ============================================================================
module ppu_scroll_address_unit
  import psa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        mode,
  input  logic [7:0]        data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] vram_addr,
  output logic [ADDR_W-1:0] temp_addr,
  output logic [2:0]        fine_x,
  output logic              write_toggle,
  output logic [CNT_W-1:0]  dot,
  output logic [CNT_W-1:0]  scanline,
  output logic              odd_frame
);

  logic          q_valid;
  logic [2:0]    q_mode;
  logic [7:0]    q_data;
  logic          adv;
  logic          is_tick;

  scroll_state_t st;
  scroll_state_t st_next;
  logic [CNT_W-1:0] dot_cnt;
  logic [CNT_W-1:0] line_cnt;
  logic             parity;
  logic [CNT_W-1:0] dot_next;
  logic [CNT_W-1:0] line_next;
  logic             parity_next;
  dot_act_t         acts;

  // An item moves into the result register when the output slot is empty or
  // is being emptied at this edge.
  assign adv     = q_valid && (!out_valid || out_ready);
  assign is_tick = (q_mode == MODE_TICK);

  psa_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .data_byte (data_byte),
    .take      (adv),
    .q_valid   (q_valid),
    .q_mode    (q_mode),
    .q_data    (q_data)
  );

  psa_dot_timer u_timer (
    .dot         (dot_cnt),
    .scanline    (line_cnt),
    .odd_frame   (parity),
    .render      (st.render),
    .dot_next    (dot_next),
    .line_next   (line_next),
    .parity_next (parity_next),
    .acts        (acts)
  );

  psa_addr_update u_addr (
    .mode    (q_mode),
    .data    (q_data),
    .st      (st),
    .acts    (acts),
    .st_next (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // State registers; their contents are the output item.
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= '0;
      dot_cnt  <= DOT_LAST;
      line_cnt <= LINE_RESET;
      parity   <= 1'b0;
    end else if (adv) begin
      st <= st_next;
      if (is_tick) begin
        dot_cnt  <= dot_next;
        line_cnt <= line_next;
        parity   <= parity_next;
      end
    end
  end

  assign vram_addr    = st.cur;
  assign temp_addr    = st.lat;
  assign fine_x       = st.fine;
  assign write_toggle = st.toggle;
  assign dot          = dot_cnt;
  assign scanline     = line_cnt;
  assign odd_frame    = parity;

`ifndef NO_ASSERTIONS
  // The reported state moves only when an item enters the result register.
  a_hold_without_adv: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vram_addr) && $stable(temp_addr) && $stable(dot) &&
             $stable(scanline))
    else $error("state changed without an item");

  // End of a visible or blanking line moves to dot 0 of the next line.
  a_line_advance: assert property (@(posedge clk) disable iff (rst)
    adv && is_tick && (dot_cnt == DOT_LAST) && (line_cnt < LINE_PRE)
    |=> (dot == '0) && (scanline == $past(scanline) + 9'd1))
    else $error("line advance wrong");

  // Frame parity flips only at the wrap of the pre-render line.
  a_parity_only_at_wrap: assert property (@(posedge clk) disable iff (rst)
    adv && !(is_tick && (dot_cnt >= DOT_LAST) && (line_cnt >= LINE_PRE))
    |=> $stable(odd_frame))
    else $error("frame parity changed mid-frame");

  // A status read always leaves the toggle on the first write.
  a_status_clears_toggle: assert property (@(posedge clk) disable iff (rst)
    adv && (q_mode == MODE_STATUS) |=> !write_toggle)
    else $error("status read did not clear toggle");
`endif

endmodule

### sv/psa_in_stage.sv
// ============================================================================
// psa_in_stage: input register
// Holds one accepted event until the state update takes it.
// ============================================================================
module psa_in_stage
  import psa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] mode,
  input  logic [7:0] data_byte,
  input  logic       take,
  output logic       q_valid,
  output logic [2:0] q_mode,
  output logic [7:0] q_data
);

  logic load;

  // The register frees up in the same cycle its item is taken.
  assign in_ready = !q_valid || take;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (load) begin
      q_valid <= 1'b1;
    end else if (take) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_mode <= mode;
      q_data <= data_byte;
    end
  end

endmodule

### sv/psa_dot_timer.sv
// ============================================================================
// psa_dot_timer: dot and scanline timing
// Next dot, scanline and frame parity for a tick, and the address actions
// due at the new dot.
// ============================================================================
module psa_dot_timer
  import psa_pkg::*;
(
  input  logic [CNT_W-1:0] dot,
  input  logic [CNT_W-1:0] scanline,
  input  logic             odd_frame,
  input  logic             render,
  output logic [CNT_W-1:0] dot_next,
  output logic [CNT_W-1:0] line_next,
  output logic             parity_next,
  output dot_act_t         acts
);

  logic active;
  logic in_range;

  always_comb begin
    dot_next    = dot + 9'd1;
    line_next   = scanline;
    parity_next = odd_frame;
    if (dot >= DOT_LAST) begin
      dot_next = '0;
      if (scanline >= LINE_PRE) begin
        line_next   = '0;
        parity_next = ~odd_frame;
        // Odd frames with rendering on skip dot 0.
        dot_next    = {8'd0, render & ~odd_frame};
      end else begin
        line_next = scanline + 9'd1;
      end
    end
  end

  always_comb begin
    active   = render && ((line_next <= LINE_VIS_LAST) || (line_next == LINE_PRE));
    in_range = (dot_next <= DOT_XY) || (dot_next >= DOT_PREFETCH);
    acts.inc_xy = active && (dot_next == DOT_XY);
    acts.copy_h = active && (dot_next == DOT_HCOPY);
    acts.copy_v = active && (line_next == LINE_PRE) &&
                  (dot_next >= DOT_VCOPY_LO) && (dot_next <= DOT_VCOPY_HI);
    acts.inc_x  = active && (dot_next != DOT_XY) && (dot_next != '0) && in_range &&
                  (dot_next[2:0] == 3'd0);
  end

endmodule

### sv/psa_addr_update.sv
// ============================================================================
// psa_addr_update: address-side next state
// Applies one event to the current and temporary addresses, fine X, the
// write toggle, the data-port step and the rendering enable.
// ============================================================================
module psa_addr_update
  import psa_pkg::*;
(
  input  logic [2:0]    mode,
  input  logic [7:0]    data,
  input  scroll_state_t st,
  input  dot_act_t      acts,
  output scroll_state_t st_next
);

  always_comb begin
    st_next = st;
    unique case (mode_t'(mode))
      MODE_CTRL: begin
        st_next.step_row  = data[2];
        st_next.lat[11:10] = data[1:0];
      end
      MODE_MASK: begin
        st_next.render = data[3] | data[4];
      end
      MODE_SCROLL: begin
        if (!st.toggle) begin
          st_next.lat[4:0] = data[7:3];
          st_next.fine     = data[2:0];
        end else begin
          st_next.lat = {data[2:0], st.lat[11:10], data[7:3], st.lat[4:0]};
        end
        st_next.toggle = ~st.toggle;
      end
      MODE_ADDR: begin
        if (!st.toggle) begin
          st_next.lat = {1'b0, data[5:0], st.lat[7:0]};
        end else begin
          st_next.lat = {st.lat[14:8], data};
          st_next.cur = {st.lat[14:8], data};
        end
        st_next.toggle = ~st.toggle;
      end
      MODE_DATA: begin
        st_next.cur = st.cur + (st.step_row ? ROW_STEP : COL_STEP);
      end
      MODE_STATUS: begin
        st_next.toggle = 1'b0;
      end
      MODE_TICK: begin
        priority if (acts.inc_xy) begin
          st_next.cur = bump_y(bump_x(st.cur));
        end else if (acts.copy_h) begin
          st_next.cur = (st.cur & ~MASK_H) | (st.lat & MASK_H);
        end else if (acts.copy_v) begin
          st_next.cur = (st.cur & MASK_H) | (st.lat & MASK_V);
        end else if (acts.inc_x) begin
          st_next.cur = bump_x(st.cur);
        end else begin
          st_next.cur = st.cur;
        end
      end
      default: begin
        st_next = st;
      end
    endcase
  end

endmodule
